FILE: hdl/oale_pkg.sv
package oale_pkg;

	typedef enum logic [3:0] {
		OP_PUSH_BACK    = 4'd0,
		OP_POP_BACK     = 4'd1,
		OP_PUSH_FRONT   = 4'd2,
		OP_POP_FRONT    = 4'd3,
		OP_INSERT       = 4'd4,
		OP_DELETE       = 4'd5,
		OP_FIND         = 4'd6,
		OP_REMOVE_FIRST = 4'd7,
		OP_REMOVE_ALL   = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_RANGE    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_DRAIN,
		ST_PUT,
		ST_RD_FRONT,
		ST_RD_BACK,
		ST_CAP
	} state_t;

	typedef enum logic [1:0] {
		MODE_AT,
		MODE_FIND,
		MODE_FIRST,
		MODE_ALL
	} mode_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [5:0]         found_index;
		logic [6:0]         removed_number;
		logic [6:0]         element_count;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic               is_empty;
	} result_t;

endpackage

FILE: hdl/oale_req_if.sv
interface oale_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         kind;
	logic signed [31:0] value;
	logic [6:0]         position;

	modport source (output valid, output kind, output value, output position, input ready);
	modport sink (input valid, input kind, input value, input position, output ready);
endinterface

FILE: hdl/oale_rsp_if.sv
interface oale_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [5:0]         found_index;
	logic [6:0]         removed_number;
	logic [6:0]         element_count;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic               is_empty;

	modport source (
		output valid, output status, output found_index, output removed_number,
		output element_count, output front_value, output back_value, output is_empty,
		input ready
	);
	modport sink (
		input valid, input status, input found_index, input removed_number,
		input element_count, input front_value, input back_value, input is_empty,
		output ready
	);
endinterface

FILE: hdl/oale_ram.sv
module oale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/oale_seq.sv
module oale_seq #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  oale_pkg::req_t           req,
	output logic                     idle,
	output logic                     done,
	input  logic                     take,
	output oale_pkg::result_t        res,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [WIDTH-1:0]         ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [WIDTH-1:0]         ram_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int DW = (WIDTH > 32) ? WIDTH : 32;

	oale_pkg::state_t  state_q, state_d;
	oale_pkg::mode_t   mode_q;
	oale_pkg::status_t status_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     tgt_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     keep_q;
	logic [CW-1:0]     rm_q;
	logic              ins_q;
	logic              hit_q;
	logic [AW-1:0]     found_q;
	logic [WIDTH-1:0]  val_q;
	logic [31:0]       front_q;
	logic              rv_s1;
	logic [CW-1:0]     ridx_s1;

	oale_pkg::state_t  dec_state;
	oale_pkg::status_t dec_status;
	oale_pkg::mode_t   dec_mode;
	logic              dec_ins;
	logic [CW-1:0]     dec_tgt;
	logic [CW-1:0]     dec_idx;
	logic [CW-1:0]     dec_cnt;
	logic [CW-1:0]     dec_rm;

	logic [63:0]       val_ext;
	logic [WIDTH-1:0]  req_val;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              full;
	logic              empty;
	logic              eq;
	logic              match;
	logic              drop;
	logic              wr_dn;
	logic              hit_nxt;
	logic [CW-1:0]     keep_nxt;
	logic [CW-1:0]     up_addr;
	logic [CW-1:0]     last_idx;
	logic [DW-1:0]     rdata_x;
	logic [XW-1:0]     found_x;
	logic [XW-1:0]     rm_x;

	assign val_ext  = {32'b0, req.value};
	assign req_val  = val_ext[WIDTH-1:0];
	assign pos_x    = XW'(req.position);
	assign cnt_x    = XW'(cnt_q);
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign last_idx = cnt_q - CW'(1);
	assign up_addr  = ridx_s1 + CW'(1);
	assign rdata_x  = DW'(ram_rdata);

	// decode the accepted operation
	always_comb begin
		dec_state  = oale_pkg::ST_RD_FRONT;
		dec_status = oale_pkg::STAT_OK;
		dec_mode   = oale_pkg::MODE_ALL;
		dec_ins    = 1'b0;
		dec_tgt    = '0;
		dec_idx    = '0;
		dec_cnt    = cnt_q;
		dec_rm     = '0;
		unique case (req.kind)
			oale_pkg::OP_PUSH_BACK: begin
				if (full) begin
					dec_status = oale_pkg::STAT_FULL;
				end else begin
					dec_ins   = 1'b1;
					dec_tgt   = cnt_q;
					dec_state = oale_pkg::ST_PUT;
				end
			end
			oale_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					dec_status = oale_pkg::STAT_FULL;
				end else begin
					dec_ins   = 1'b1;
					dec_idx   = last_idx;
					dec_state = empty ? oale_pkg::ST_PUT : oale_pkg::ST_SHIFT_UP;
				end
			end
			oale_pkg::OP_INSERT: begin
				if (pos_x > cnt_x) begin
					dec_status = oale_pkg::STAT_RANGE;
				end else if (full) begin
					dec_status = oale_pkg::STAT_FULL;
				end else begin
					dec_ins   = 1'b1;
					dec_tgt   = pos_x[CW-1:0];
					dec_idx   = last_idx;
					dec_state = (pos_x == cnt_x) ? oale_pkg::ST_PUT : oale_pkg::ST_SHIFT_UP;
				end
			end
			oale_pkg::OP_POP_BACK: begin
				if (empty) begin
					dec_status = oale_pkg::STAT_EMPTY;
				end else begin
					dec_cnt = last_idx;
					dec_rm  = CW'(1);
				end
			end
			oale_pkg::OP_POP_FRONT: begin
				if (empty) begin
					dec_status = oale_pkg::STAT_EMPTY;
				end else begin
					dec_mode  = oale_pkg::MODE_AT;
					dec_state = oale_pkg::ST_SHIFT_DN;
				end
			end
			oale_pkg::OP_DELETE: begin
				if (empty) begin
					dec_status = oale_pkg::STAT_EMPTY;
				end else if (pos_x >= cnt_x) begin
					dec_status = oale_pkg::STAT_RANGE;
				end else begin
					dec_mode  = oale_pkg::MODE_AT;
					dec_tgt   = pos_x[CW-1:0];
					dec_idx   = pos_x[CW-1:0];
					dec_state = oale_pkg::ST_SHIFT_DN;
				end
			end
			oale_pkg::OP_FIND, oale_pkg::OP_REMOVE_FIRST, oale_pkg::OP_REMOVE_ALL: begin
				if (req.kind == oale_pkg::OP_FIND) begin
					dec_mode = oale_pkg::MODE_FIND;
				end else if (req.kind == oale_pkg::OP_REMOVE_FIRST) begin
					dec_mode = oale_pkg::MODE_FIRST;
				end else begin
					dec_mode = oale_pkg::MODE_ALL;
				end
				if (empty) begin
					dec_status = oale_pkg::STAT_NOTFOUND;
				end else begin
					dec_state = oale_pkg::ST_SHIFT_DN;
				end
			end
			default: begin
				dec_state = oale_pkg::ST_RD_FRONT;
			end
		endcase
	end

	// write-back decision for the element returned by the previous read
	always_comb begin
		eq = (ram_rdata == val_q);
		unique case (mode_q)
			oale_pkg::MODE_AT: match = (ridx_s1 == tgt_q);
			oale_pkg::MODE_FIND,
			oale_pkg::MODE_FIRST,
			oale_pkg::MODE_ALL: match = eq;
		endcase
		drop     = rv_s1 && match && (mode_q != oale_pkg::MODE_FIND)
			&& !((mode_q == oale_pkg::MODE_FIRST) && hit_q);
		wr_dn    = rv_s1 && !drop && (mode_q != oale_pkg::MODE_FIND);
		hit_nxt  = hit_q || (rv_s1 && match);
		keep_nxt = keep_q + CW'(wr_dn);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oale_pkg::ST_IDLE: begin
				if (start) begin
					state_d = dec_state;
				end
			end
			oale_pkg::ST_SHIFT_UP: begin
				if (idx_q == tgt_q) begin
					state_d = oale_pkg::ST_DRAIN;
				end
			end
			oale_pkg::ST_SHIFT_DN: begin
				if (idx_q == last_idx) begin
					state_d = oale_pkg::ST_DRAIN;
				end
			end
			oale_pkg::ST_DRAIN: state_d = ins_q ? oale_pkg::ST_PUT : oale_pkg::ST_RD_FRONT;
			oale_pkg::ST_PUT: state_d = oale_pkg::ST_RD_FRONT;
			oale_pkg::ST_RD_FRONT: state_d = oale_pkg::ST_RD_BACK;
			oale_pkg::ST_RD_BACK: state_d = oale_pkg::ST_CAP;
			oale_pkg::ST_CAP: begin
				if (take) begin
					state_d = oale_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			oale_pkg::ST_SHIFT_UP: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[AW-1:0];
				ram_we    = rv_s1;
				ram_waddr = up_addr[AW-1:0];
			end
			oale_pkg::ST_SHIFT_DN: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[AW-1:0];
				ram_we    = wr_dn;
				ram_waddr = keep_q[AW-1:0];
			end
			oale_pkg::ST_DRAIN: begin
				if (ins_q) begin
					ram_we    = rv_s1;
					ram_waddr = up_addr[AW-1:0];
				end else begin
					ram_we    = wr_dn;
					ram_waddr = keep_q[AW-1:0];
				end
			end
			oale_pkg::ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q[AW-1:0];
				ram_wdata = val_q;
			end
			oale_pkg::ST_RD_FRONT: begin
				ram_re = 1'b1;
			end
			oale_pkg::ST_RD_BACK: begin
				ram_re    = 1'b1;
				ram_raddr = last_idx[AW-1:0];
			end
			oale_pkg::ST_IDLE, oale_pkg::ST_CAP: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oale_pkg::ST_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == oale_pkg::ST_SHIFT_UP) || (state_q == oale_pkg::ST_SHIFT_DN);
			if (state_q == oale_pkg::ST_IDLE && start) begin
				cnt_q <= dec_cnt;
			end else if (state_q == oale_pkg::ST_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == oale_pkg::ST_DRAIN && !ins_q
				&& mode_q != oale_pkg::MODE_FIND) begin
				cnt_q <= keep_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		unique case (state_q)
			oale_pkg::ST_IDLE: begin
				if (start) begin
					mode_q   <= dec_mode;
					status_q <= dec_status;
					ins_q    <= dec_ins;
					tgt_q    <= dec_tgt;
					idx_q    <= dec_idx;
					keep_q   <= dec_idx;
					rm_q     <= dec_rm;
					hit_q    <= 1'b0;
					found_q  <= '0;
					val_q    <= req_val;
				end
			end
			oale_pkg::ST_SHIFT_UP: begin
				idx_q <= idx_q - CW'(1);
			end
			oale_pkg::ST_SHIFT_DN, oale_pkg::ST_DRAIN: begin
				if (state_q == oale_pkg::ST_SHIFT_DN) begin
					idx_q <= idx_q + CW'(1);
				end
				if (!ins_q) begin
					keep_q <= keep_nxt;
					hit_q  <= hit_nxt;
					if (mode_q == oale_pkg::MODE_FIND && rv_s1 && eq && !hit_q) begin
						found_q <= ridx_s1[AW-1:0];
					end
				end
				if (state_q == oale_pkg::ST_DRAIN && !ins_q) begin
					if (mode_q != oale_pkg::MODE_FIND) begin
						rm_q <= cnt_q - keep_nxt;
					end
					if (mode_q != oale_pkg::MODE_AT && !hit_nxt) begin
						status_q <= oale_pkg::STAT_NOTFOUND;
					end
				end
			end
			oale_pkg::ST_RD_BACK: begin
				front_q <= rdata_x[31:0];
			end
			oale_pkg::ST_PUT, oale_pkg::ST_RD_FRONT, oale_pkg::ST_CAP: begin
				front_q <= front_q;
			end
		endcase
	end

	assign idle    = (state_q == oale_pkg::ST_IDLE);
	assign done    = (state_q == oale_pkg::ST_CAP);
	assign found_x = XW'(found_q);
	assign rm_x    = XW'(rm_q);

	always_comb begin
		res.status         = status_q;
		res.found_index    = found_x[5:0];
		res.removed_number = rm_x[6:0];
		res.element_count  = cnt_x[6:0];
		res.is_empty       = empty;
		res.front_value    = empty ? 32'sd0 : front_q;
		res.back_value     = empty ? 32'sd0 : rdata_x[31:0];
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above capacity");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == oale_pkg::ST_SHIFT_UP || state_q == oale_pkg::ST_SHIFT_DN
			|| state_q == oale_pkg::ST_DRAIN || state_q == oale_pkg::ST_PUT))
		else $error("memory write outside a modify phase");

	a_dn_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oale_pkg::ST_SHIFT_DN && ram_we) |-> (ram_waddr < ram_raddr))
		else $error("compaction write overtakes its read");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oale_pkg::ST_IDLE && !start) |=> $stable(cnt_q))
		else $error("element count changed while idle");
`endif

endmodule

FILE: hdl/ordered_array_list_engine.sv
// Ordered array list engine.
// Channel req carries one operation per transaction (kind, value, position):
// push or pop at either end, insert or delete at a position, find, remove the
// first match or remove every match. Channel rsp returns exactly one
// transaction per request with status, found index, removed count, element
// count, front and back values and an empty flag, in request order.
// The list lives in one RAM of DEPTH entries with one read and one write port;
// each shift or scan reads through it and writes moved elements back, one
// element per cycle. After acceptance the engine walks any elements the
// operation needs (ST_SHIFT_UP or ST_SHIFT_DN, then ST_DRAIN), writes a new
// element in ST_PUT for a push or insert, reads the front and back values in
// ST_RD_FRONT and ST_RD_BACK, then waits in ST_CAP; pop back, rejected and
// unknown operations go straight to the reads. Only one operation is in
// flight; req.ready is high only while the engine is idle.
// The response sits in an output register; a new request is accepted while
// it waits, and the engine holds in its final step until rsp.ready frees
// that register. Reset clears the element count and the control state; no
// RAM clearing pass is run, and rsp.valid is low after reset.
module ordered_array_list_engine #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	oale_req_if.sink   req,
	oale_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	oale_pkg::req_t    req_d;
	oale_pkg::result_t res;
	oale_pkg::result_t rsp_q;
	logic              rsp_valid_q;
	logic              start;
	logic              idle;
	logic              done;
	logic              take;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WIDTH-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WIDTH-1:0]  ram_rdata;

	assign req_d.kind     = req.kind;
	assign req_d.value    = req.value;
	assign req_d.position = req.position;
	assign req.ready      = idle;
	assign start          = req.valid && idle;
	assign take           = !rsp_valid_q || rsp.ready;

	oale_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	oale_seq #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req_d),
		.idle      (idle),
		.done      (done),
		.take      (take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done && take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_q.status;
	assign rsp.found_index    = rsp_q.found_index;
	assign rsp.removed_number = rsp_q.removed_number;
	assign rsp.element_count  = rsp_q.element_count;
	assign rsp.front_value    = rsp_q.front_value;
	assign rsp.back_value     = rsp_q.back_value;
	assign rsp.is_empty       = rsp_q.is_empty;

endmodule

FILE: tb/ordered_array_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_array_list_engine_tb;

	localparam int LIST_DEPTH = 64;
	localparam int STALL_LIMIT = 4000;
	localparam int TARGET_OPS = 1050;

	logic clk;
	logic arst_n;
	bit   go;

	oale_req_if req_ch ();
	oale_rsp_if rsp_ch ();

	ordered_array_list_engine #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(32)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// list contents as the engine should hold them
	logic [31:0] list_mem [LIST_DEPTH];
	int          list_len;

	oale_pkg::req_t    op_queue [$];
	oale_pkg::result_t list_outcome_q [$];
	int                issued;
	int                answered;
	int                mismatches;
	int                stall_cycles;
	int                hold_left;
	bit                hold_done;
	bit                req_taken;

	function automatic void insert_at(input int pos, input logic [31:0] val);
		int i;
		for (i = list_len; i > pos; i--)
			list_mem[i] = list_mem[i - 1];
		list_mem[pos] = val;
		list_len++;
	endfunction

	function automatic void remove_at(input int pos);
		int i;
		for (i = pos; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	function automatic int locate(input logic [31:0] val);
		int i;
		for (i = 0; i < list_len; i++)
			if (list_mem[i] == val)
				return i;
		return -1;
	endfunction

	function automatic oale_pkg::result_t apply_list_op(input logic [3:0] kind,
			input logic [31:0] val, input logic [6:0] pos);
		oale_pkg::result_t r;
		int                idx;
		int                keep;
		int                i;
		r = '0;
		r.status = oale_pkg::STAT_OK;
		case (kind)
			oale_pkg::OP_PUSH_BACK, oale_pkg::OP_PUSH_FRONT: begin
				if (list_len >= LIST_DEPTH)
					r.status = oale_pkg::STAT_FULL;
				else
					insert_at((kind == oale_pkg::OP_PUSH_BACK) ? list_len : 0, val);
			end
			oale_pkg::OP_POP_BACK, oale_pkg::OP_POP_FRONT: begin
				if (list_len == 0) begin
					r.status = oale_pkg::STAT_EMPTY;
				end else begin
					if (kind == oale_pkg::OP_POP_BACK)
						list_len--;
					else
						remove_at(0);
					r.removed_number = 7'd1;
				end
			end
			oale_pkg::OP_INSERT: begin
				if (int'(pos) > list_len)
					r.status = oale_pkg::STAT_RANGE;
				else if (list_len >= LIST_DEPTH)
					r.status = oale_pkg::STAT_FULL;
				else
					insert_at(int'(pos), val);
			end
			oale_pkg::OP_DELETE: begin
				if (list_len == 0) begin
					r.status = oale_pkg::STAT_EMPTY;
				end else if (int'(pos) >= list_len) begin
					r.status = oale_pkg::STAT_RANGE;
				end else begin
					remove_at(int'(pos));
					r.removed_number = 7'd1;
				end
			end
			oale_pkg::OP_FIND: begin
				idx = locate(val);
				if (idx < 0)
					r.status = oale_pkg::STAT_NOTFOUND;
				else
					r.found_index = idx[5:0];
			end
			oale_pkg::OP_REMOVE_FIRST: begin
				idx = locate(val);
				if (idx < 0) begin
					r.status = oale_pkg::STAT_NOTFOUND;
				end else begin
					remove_at(idx);
					r.removed_number = 7'd1;
				end
			end
			oale_pkg::OP_REMOVE_ALL: begin
				keep = 0;
				for (i = 0; i < list_len; i++) begin
					if (list_mem[i] != val) begin
						list_mem[keep] = list_mem[i];
						keep++;
					end
				end
				r.removed_number = 7'(list_len - keep);
				list_len = keep;
				if (r.removed_number == 0)
					r.status = oale_pkg::STAT_NOTFOUND;
			end
			default: ;
		endcase
		r.element_count = 7'(list_len);
		if (list_len == 0) begin
			r.is_empty = 1'b1;
		end else begin
			r.front_value = list_mem[0];
			r.back_value = list_mem[list_len - 1];
		end
		return r;
	endfunction

	function automatic void add_op(input logic [3:0] kind, input logic [31:0] val,
			input logic [6:0] pos);
		oale_pkg::req_t item;
		item.kind = kind;
		item.value = val;
		item.position = pos;
		op_queue.push_back(item);
	endfunction

	// mostly a small pool so that searches hit and duplicates build up
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = 32'd1;
			2: v = 32'hFFFF_FFFF;
			3: v = 32'h8000_0000;
			4: v = 32'h7FFF_FFFF;
			5: v = 32'd3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] pick_position();
		logic [6:0] p;
		case ($urandom_range(0, 9))
			0: p = 7'($urandom_range(0, 127));
			1, 2: p = 7'($urandom_range(0, 64));
			default: p = 7'($urandom_range(0, 10));
		endcase
		return p;
	endfunction

	task automatic report(input string what, input oale_pkg::result_t exp_r,
			input oale_pkg::result_t got_r);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s exp st=%0d idx=%0d rm=%0d n=%0d f=%0d b=%0d e=%0b",
				$realtime, what, exp_r.status, exp_r.found_index, exp_r.removed_number,
				exp_r.element_count, exp_r.front_value, exp_r.back_value, exp_r.is_empty);
			$display("%0t %s got st=%0d idx=%0d rm=%0d n=%0d f=%0d b=%0d e=%0b",
				$realtime, what, got_r.status, got_r.found_index, got_r.removed_number,
				got_r.element_count, got_r.front_value, got_r.back_value, got_r.is_empty);
		end
	endtask

	// check results, then predict the transaction taken at this edge
	always @(posedge clk) begin
		oale_pkg::result_t got_r;
		oale_pkg::result_t exp_r;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_r = {rsp_ch.status, rsp_ch.found_index, rsp_ch.removed_number,
					rsp_ch.element_count, rsp_ch.front_value, rsp_ch.back_value,
					rsp_ch.is_empty};
				answered++;
				if (list_outcome_q.size() == 0) begin
					report("unexpected result", '0, got_r);
				end else begin
					exp_r = list_outcome_q.pop_front();
					if (got_r.status !== exp_r.status ||
							got_r.found_index !== exp_r.found_index ||
							got_r.removed_number !== exp_r.removed_number ||
							got_r.element_count !== exp_r.element_count ||
							got_r.front_value !== exp_r.front_value ||
							got_r.back_value !== exp_r.back_value ||
							got_r.is_empty !== exp_r.is_empty)
						report("mismatch", exp_r, got_r);
				end
			end
			if (req_ch.valid && req_ch.ready)
				list_outcome_q.push_back(apply_list_op(req_ch.kind, req_ch.value,
					req_ch.position));
		end
		req_taken <= req_ch.valid && req_ch.ready;
	end

	always @(negedge clk) begin
		oale_pkg::req_t item;
		if (!go) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (op_queue.size() > 0 &&
					!((issued < 600 || issued >= 800) && $urandom_range(0, 99) < 25)) begin
				item = op_queue.pop_front();
				req_ch.kind <= item.kind;
				req_ch.value <= item.value;
				req_ch.position <= item.position;
				req_ch.valid <= 1'b1;
				issued++;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// hold off the result side once for a long stretch
	always @(negedge clk) begin
		if (!go) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (answered >= 300 && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 400;
			rsp_ch.ready <= 1'b0;
		end else if (answered >= 600 && answered < 800) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int          real_ops;
		int          n;
		int          i;
		int          roll;
		logic [31:0] base;
		logic [3:0]  kind;

		arst_n = 1'b0;
		go = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = oale_pkg::OP_PUSH_BACK;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		list_len = 0;
		issued = 0;
		answered = 0;
		mismatches = 0;
		stall_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		req_taken = 1'b0;

		add_op(oale_pkg::OP_POP_BACK, 32'd0, 7'd0);
		add_op(oale_pkg::OP_POP_FRONT, 32'd0, 7'd0);
		add_op(oale_pkg::OP_DELETE, 32'd0, 7'd0);
		add_op(oale_pkg::OP_FIND, 32'd0, 7'd0);
		add_op(oale_pkg::OP_REMOVE_FIRST, 32'd0, 7'd0);
		add_op(oale_pkg::OP_REMOVE_ALL, 32'd0, 7'd0);
		add_op(oale_pkg::OP_INSERT, 32'd9, 7'd1);
		add_op(oale_pkg::OP_INSERT, 32'h8000_0000, 7'd0);
		add_op(oale_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_FIND, 32'hFFFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_FIND, 32'h7FFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_DELETE, 32'd0, 7'd4);
		add_op(oale_pkg::OP_DELETE, 32'd0, 7'd127);
		add_op(oale_pkg::OP_INSERT, 32'd0, 7'd127);
		add_op(4'd9, 32'd123, 7'd1);
		add_op(4'd15, 32'hFFFF_FFFF, 7'd127);
		add_op(oale_pkg::OP_REMOVE_ALL, 32'hFFFF_FFFF, 7'd0);
		add_op(oale_pkg::OP_INSERT, 32'd5, 7'd2);
		add_op(oale_pkg::OP_DELETE, 32'd0, 7'd0);
		add_op(oale_pkg::OP_REMOVE_FIRST, 32'd5, 7'd0);
		add_op(oale_pkg::OP_POP_FRONT, 32'd0, 7'd0);
		add_op(oale_pkg::OP_POP_BACK, 32'd0, 7'd0);

		real_ops = 0;
		while (real_ops < TARGET_OPS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// empty, fill with distinct values, then work the full list
				base = $urandom;
				for (i = 0; i < LIST_DEPTH + 2; i++)
					add_op(($urandom_range(0, 1) != 0) ? oale_pkg::OP_POP_BACK
						: oale_pkg::OP_POP_FRONT, $urandom, pick_position());
				for (i = 0; i < LIST_DEPTH; i++)
					add_op(oale_pkg::OP_PUSH_BACK, base + 32'(i), 7'd0);
				add_op(oale_pkg::OP_PUSH_FRONT, pick_value(), 7'd0);
				add_op(oale_pkg::OP_PUSH_BACK, pick_value(), 7'd0);
				add_op(oale_pkg::OP_INSERT, pick_value(), 7'd64);
				add_op(oale_pkg::OP_INSERT, pick_value(), 7'd65);
				add_op(oale_pkg::OP_DELETE, 32'd0, 7'd64);
				add_op(oale_pkg::OP_FIND, base + 32'(LIST_DEPTH - 1), 7'd0);
				add_op(oale_pkg::OP_FIND, base, 7'd0);
				add_op(oale_pkg::OP_FIND,
					base + 32'($urandom_range(0, LIST_DEPTH - 1)), 7'd0);
				add_op(oale_pkg::OP_DELETE, 32'd0, 7'd63);
				add_op(oale_pkg::OP_INSERT, $urandom, 7'd63);
				add_op(oale_pkg::OP_REMOVE_FIRST,
					base + 32'($urandom_range(0, LIST_DEPTH - 1)), 7'd0);
				add_op(oale_pkg::OP_INSERT, $urandom, 7'd0);
				add_op(oale_pkg::OP_REMOVE_ALL, pick_value(), 7'd0);
				real_ops += 2 * LIST_DEPTH + 15;
			end else if (roll < 40) begin
				n = $urandom_range(10, 50);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 2))
						0: kind = oale_pkg::OP_PUSH_BACK;
						1: kind = oale_pkg::OP_PUSH_FRONT;
						default: kind = oale_pkg::OP_INSERT;
					endcase
					add_op(kind, pick_value(), pick_position());
				end
				real_ops += n;
			end else if (roll < 65) begin
				n = $urandom_range(10, 50);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 4))
						0: kind = oale_pkg::OP_POP_BACK;
						1: kind = oale_pkg::OP_POP_FRONT;
						2: kind = oale_pkg::OP_DELETE;
						3: kind = oale_pkg::OP_REMOVE_FIRST;
						default: kind = oale_pkg::OP_REMOVE_ALL;
					endcase
					add_op(kind, pick_value(), pick_position());
				end
				real_ops += n;
			end else if (roll < 88) begin
				n = $urandom_range(10, 40);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 5))
						0, 1: kind = oale_pkg::OP_FIND;
						2: kind = oale_pkg::OP_REMOVE_FIRST;
						3: kind = oale_pkg::OP_REMOVE_ALL;
						default: kind = oale_pkg::OP_PUSH_BACK;
					endcase
					add_op(kind, pick_value(), pick_position());
				end
				real_ops += n;
			end else begin
				n = $urandom_range(5, 20);
				for (i = 0; i < n; i++) begin
					kind = 4'($urandom_range(0, 15));
					add_op(kind, $urandom, 7'($urandom_range(0, 127)));
					if (kind <= oale_pkg::OP_REMOVE_ALL)
						real_ops++;
				end
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		go = 1'b1;

		while (op_queue.size() > 0 || req_ch.valid || list_outcome_q.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0 && list_outcome_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
